// ===== hdl/robust_outlier_input_counter_core_assert.svh =====
// assertion macros for the outlier counter core
`ifndef ROBUST_OUTLIER_INPUT_COUNTER_CORE_ASSERT_SVH
`define ROBUST_OUTLIER_INPUT_COUNTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ROIC_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("implication check failed");
`define ROIC_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");
`else
`define ROIC_ASSERT_IMPLY(label, clk, rst, a, b)
`define ROIC_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== hdl/roic_pkg.sv =====
`default_nettype none
package roic_pkg;
   localparam int MAX_INPUTS  = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int IDX_BITS    = $clog2(MAX_INPUTS);
   localparam int LEN_BITS    = $clog2(MAX_INPUTS + 1);
   localparam int SQ_BITS     = 2 * SAMPLE_BITS;
   localparam int SUM_BITS    = SQ_BITS + IDX_BITS;
   localparam int RHS_BITS    = SUM_BITS + 8;
   localparam int T_BITS      = SQ_BITS + LEN_BITS;
   localparam int CSR_BITS    = 16;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ACTIVE_INPUTS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAMES        = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIGMA         = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CUT           = 2'd3;

   typedef struct packed {
      logic load;
      logic shift;
      logic med_cap;
      logic var_rd;
      logic var_sq;
      logic var_acc;
      logic rhs;
      logic flag_rd;
      logic flag_sq;
      logic flag_mul;
      logic flag_upd;
      logic frame_end;
      logic rep_rd;
      logic rep_out;
   } cmd_type;

   typedef struct packed {
      logic frame_close;
      logic shift_done;
      logic idx_last;
      logic clip_ok;
      logic report_due;
   } status_type;
endpackage
`default_nettype wire

// ===== hdl/robust_outlier_input_counter_core.sv =====
// a sample that does not close a frame is taken while busy stays low
// a closing sample holds busy for the median shift-out and the variance walk, plus the flag
// walk when two or more samples fall in the clip window, plus the report when it is due
// the variance and flag walks each read the single sample memory port once per input
// no two report transfers come back to back; the receiver cannot stall
// synchronous active-high reset: counters, valid bits, state and CSRs return to defaults
`default_nettype none
module robust_outlier_input_counter_core import roic_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [SAMPLE_BITS-1:0]  req_sample,
   input  wire logic                    csr_write_enable,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [CSR_BITS-1:0]     csr_wdata,
   output logic                         rsp_valid,
   output logic [IDX_BITS-1:0]          rsp_input_index,
   output logic [7:0]                   rsp_fault_count,
   output logic                         rsp_last_of_report
);
`include "robust_outlier_input_counter_core_assert.svh"

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: load, median shift-out, variance walk, flag walk, report
   roic_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // datapath: sample memory, sorted insertion row, squares and fault counts
   roic_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .sample             (req_sample),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_input_index    (rsp_input_index),
      .rsp_fault_count    (rsp_fault_count),
      .rsp_last_of_report (rsp_last_of_report)
   );

   // a report transfer is never followed directly by another
   `ROIC_ASSERT_NEXT(a_rsp_spaced, clock, reset, rsp_valid, !rsp_valid)
   // only the final transfer of a report may appear after the block is idle
   `ROIC_ASSERT_IMPLY(a_rsp_busy, clock, reset, rsp_valid && !rsp_last_of_report, busy)
   // a transfer that is not the last is followed by another, with the next read between
   `ROIC_ASSERT_NEXT(a_rsp_more, clock, reset, rsp_valid && !rsp_last_of_report, ##1 rsp_valid)
endmodule
`default_nettype wire

// ===== hdl/roic_ctrl.sv =====
`default_nettype none
module roic_ctrl import roic_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  status_type      status,
   output cmd_type         cmd,
   output logic            busy
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_MED, ST_MED_CAP, ST_V_RD, ST_V_SQ, ST_V_ACC, ST_RHS,
      ST_F_RD, ST_F_SQ, ST_F_MUL, ST_F_UPD, ST_FRAME_END, ST_R_RD, ST_R_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
            if (start && status.frame_close) state_in = ST_MED;
         end
         ST_MED: begin
            if (status.shift_done) state_in = ST_MED_CAP;
            else cmd.shift = 1'b1;
         end
         ST_MED_CAP: begin
            cmd.med_cap = 1'b1;
            state_in = ST_V_RD;
         end
         ST_V_RD: begin
            cmd.var_rd = 1'b1;
            state_in = ST_V_SQ;
         end
         ST_V_SQ: begin
            cmd.var_sq = 1'b1;
            state_in = ST_V_ACC;
         end
         ST_V_ACC: begin
            cmd.var_acc = 1'b1;
            state_in = status.idx_last ? ST_RHS : ST_V_RD;
         end
         ST_RHS: begin
            cmd.rhs = 1'b1;
            state_in = status.clip_ok ? ST_F_RD : ST_FRAME_END;
         end
         ST_F_RD: begin
            cmd.flag_rd = 1'b1;
            state_in = ST_F_SQ;
         end
         ST_F_SQ: begin
            cmd.flag_sq = 1'b1;
            state_in = ST_F_MUL;
         end
         ST_F_MUL: begin
            cmd.flag_mul = 1'b1;
            state_in = ST_F_UPD;
         end
         ST_F_UPD: begin
            cmd.flag_upd = 1'b1;
            state_in = status.idx_last ? ST_FRAME_END : ST_F_RD;
         end
         ST_FRAME_END: begin
            cmd.frame_end = 1'b1;
            state_in = status.report_due ? ST_R_RD : ST_IDLE;
         end
         ST_R_RD: begin
            cmd.rep_rd = 1'b1;
            state_in = ST_R_OUT;
         end
         ST_R_OUT: begin
            cmd.rep_out = 1'b1;
            state_in = status.idx_last ? ST_IDLE : ST_R_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);
endmodule
`default_nettype wire

// ===== hdl/roic_datapath.sv =====
`default_nettype none
module roic_datapath import roic_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  cmd_type                      cmd,
   output status_type                   status,
   input  wire logic [SAMPLE_BITS-1:0]  sample,
   input  wire logic                    csr_write_enable,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [CSR_BITS-1:0]     csr_wdata,
   output logic                         rsp_valid,
   output logic [IDX_BITS-1:0]          rsp_input_index,
   output logic [7:0]                   rsp_fault_count,
   output logic                         rsp_last_of_report
);
   // configuration
   logic [6:0]  active_ff;
   logic [7:0]  frames_ff;
   logic [3:0]  sigma_ff;
   logic [15:0] cut_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 7'd64;
         frames_ff <= 8'd10;
         sigma_ff  <= 4'd3;
         cut_ff    <= 16'd410;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ACTIVE_INPUTS: active_ff <= csr_wdata[6:0];
            CSR_FRAMES:        frames_ff <= csr_wdata[7:0];
            CSR_SIGMA:         sigma_ff  <= csr_wdata[3:0];
            CSR_CUT:           cut_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic [LEN_BITS-1:0] n_eff;
   logic [7:0]          fpr_eff;
   always_comb begin
      n_eff = active_ff[LEN_BITS-1:0];
      if (active_ff < 7'd2) n_eff = LEN_BITS'(2);
      else if (active_ff > 7'(MAX_INPUTS)) n_eff = LEN_BITS'(MAX_INPUTS);
      fpr_eff = (frames_ff == 8'd0) ? 8'd1 : frames_ff;
   end

   // counters
   logic [LEN_BITS-1:0] pos_ff, len_ff;
   logic [IDX_BITS-1:0] idx_ff, sh_ff;
   logic [7:0]          fc_ff, fc_next;
   logic [LEN_BITS-1:0] pos_next;

   assign pos_next = pos_ff + 1'b1;
   assign fc_next  = fc_ff + 8'd1;
   assign status.frame_close = (pos_next >= n_eff);
   assign status.report_due  = !(fc_next < fpr_eff);
   assign status.idx_last    = (idx_ff == IDX_BITS'(len_ff - 1'b1));
   assign status.shift_done  = (sh_ff == IDX_BITS'((len_ff - 1'b1) >> 1));

   // sample memory
   logic [SAMPLE_BITS-1:0] sample_mem [MAX_INPUTS];
   logic [SAMPLE_BITS-1:0] smp_rd_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) sample_mem[pos_ff[IDX_BITS-1:0]] <= sample;
      smp_rd_ff <= sample_mem[idx_ff];
   end

   // insertion row, kept sorted while the frame loads
   logic [SAMPLE_BITS-1:0] row_ff [MAX_INPUTS];
   logic [SAMPLE_BITS-1:0] row_in [MAX_INPUTS];
   logic [MAX_INPUTS-1:0]  lt;
   always_comb begin
      for (int i = 0; i < MAX_INPUTS; i++)
         lt[i] = (LEN_BITS'(i) < pos_ff) && (sample < row_ff[i]);
      for (int i = 0; i < MAX_INPUTS; i++) begin
         if (i > 0 && lt[(i > 0) ? i - 1 : 0]) row_in[i] = row_ff[(i > 0) ? i - 1 : 0];
         else if (lt[i] || LEN_BITS'(i) == pos_ff) row_in[i] = sample;
         else row_in[i] = row_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < MAX_INPUTS; i++) row_ff[i] <= row_in[i];
      end else if (cmd.shift) begin
         for (int i = 0; i < MAX_INPUTS - 1; i++) row_ff[i] <= row_ff[i + 1];
      end
   end

   // fault count memory, entries cleared through valid bits
   logic [7:0]            fault_mem [MAX_INPUTS];
   logic [MAX_INPUTS-1:0] fv_ff;
   logic [7:0]            fdat_ff;
   logic                  fvld_ff;
   logic [7:0]            fcur;
   assign fcur = fvld_ff ? fdat_ff : 8'd0;

   // arithmetic
   logic [SAMPLE_BITS-1:0] med_ff, diff;
   logic [SAMPLE_BITS:0]   mid_sum;
   logic [7:0]             s2_ff;
   logic [SQ_BITS-1:0]     sq_ff;
   logic                   in_ff;
   logic [SUM_BITS-1:0]    sum_ff;
   logic [LEN_BITS-1:0]    clip_ff;
   logic [RHS_BITS-1:0]    rhs_ff;
   logic [T_BITS-1:0]      t_ff;
   logic                   flag;

   assign mid_sum = {1'b0, row_ff[0]} + {1'b0, row_ff[1]};
   assign diff = (smp_rd_ff > med_ff) ? smp_rd_ff - med_ff : med_ff - smp_rd_ff;
   assign status.clip_ok = (clip_ff >= LEN_BITS'(2));
   assign flag = (RHS_BITS'(t_ff) > rhs_ff) && (fcur != 8'hFF);

   always_ff @(posedge clock) begin
      if (cmd.med_cap) begin
         med_ff  <= len_ff[0] ? row_ff[0] : mid_sum[SAMPLE_BITS:1];
         s2_ff   <= {4'd0, sigma_ff} * {4'd0, sigma_ff};
         sum_ff  <= '0;
         clip_ff <= '0;
      end
      if (cmd.var_sq || cmd.flag_sq) begin
         sq_ff <= SQ_BITS'(diff) * SQ_BITS'(diff);
         in_ff <= (diff < cut_ff);
      end
      if (cmd.var_acc && in_ff) begin
         sum_ff  <= sum_ff + SUM_BITS'(sq_ff);
         clip_ff <= clip_ff + 1'b1;
      end
      if (cmd.rhs) rhs_ff <= RHS_BITS'(sum_ff) * RHS_BITS'(s2_ff);
      if (cmd.flag_mul) t_ff <= T_BITS'(sq_ff) * T_BITS'(clip_ff - 1'b1);
      if (cmd.flag_rd || cmd.rep_rd) begin
         fdat_ff <= fault_mem[idx_ff];
         fvld_ff <= fv_ff[idx_ff];
      end
      if (cmd.flag_upd && flag) fault_mem[idx_ff] <= fcur + 8'd1;
      rsp_input_index    <= idx_ff;
      rsp_fault_count    <= fcur;
      rsp_last_of_report <= status.idx_last;
   end

   // control counters and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         len_ff    <= LEN_BITS'(2);
         idx_ff    <= '0;
         sh_ff     <= '0;
         fc_ff     <= '0;
         fv_ff     <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.rep_out;
         if (cmd.load) begin
            if (status.frame_close) begin
               len_ff <= pos_next;
               pos_ff <= '0;
               sh_ff  <= '0;
            end else begin
               pos_ff <= pos_next;
            end
         end
         if (cmd.shift) sh_ff <= sh_ff + 1'b1;
         if (cmd.med_cap || cmd.rhs || cmd.frame_end) idx_ff <= '0;
         if (cmd.var_acc || cmd.flag_upd || cmd.rep_out) idx_ff <= idx_ff + 1'b1;
         if (cmd.flag_upd && flag) fv_ff[idx_ff] <= 1'b1;
         if (cmd.frame_end) fc_ff <= status.report_due ? 8'd0 : fc_next;
         if (cmd.rep_out && status.idx_last) fv_ff <= '0;
      end
   end
endmodule
`default_nettype wire
